[rtl/core/kalman_angle_gyro_fusion_macros.svh]
// Assertion macros used by the checker file.
`ifndef KALMAN_ANGLE_GYRO_FUSION_MACROS_SVH
`define KALMAN_ANGLE_GYRO_FUSION_MACROS_SVH
// Assert that an implication holds on every clock edge outside reset.
`define KAG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert that a consequence holds in the cycle after an antecedent.
`define KAG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/core/kagf_pkg.sv]
// Package with payload types, constants and saturating arithmetic helpers.
`timescale 1ns / 1ps
package kagf_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = 31;
    localparam int IDX_WIDTH  = 2;
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;
    localparam int CNT_WIDTH  = $clog2(DIV_STEPS + 1);

    localparam logic [IDX_WIDTH-1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [IDX_WIDTH-1:0] REG_ANGLE_NOISE   = 2'd1;
    localparam logic [IDX_WIDTH-1:0] REG_BIAS_NOISE    = 2'd2;
    localparam logic [IDX_WIDTH-1:0] REG_MEAS_NOISE    = 2'd3;

    localparam logic signed [DATA_WIDTH-1:0] ONE_FX = DATA_WIDTH'(1) <<< FRAC_BITS;
    localparam logic signed [DATA_WIDTH-1:0] MAX_FX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] MIN_FX = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [CFG_WIDTH-1:0] RST_SAMPLE_PERIOD = CFG_WIDTH'(((1 << FRAC_BITS) * 2 + 50) / 100);
    localparam logic [CFG_WIDTH-1:0] RST_ANGLE_NOISE   = CFG_WIDTH'(((1 << FRAC_BITS) * 2 + 5) / 10);
    localparam logic [CFG_WIDTH-1:0] RST_BIAS_NOISE    = CFG_WIDTH'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [CFG_WIDTH-1:0] RST_MEAS_NOISE    = CFG_WIDTH'(((1 << FRAC_BITS) * 2 + 50) / 100);

    typedef logic signed [DATA_WIDTH-1:0] fx_t;

    typedef struct packed {
        logic signed [31:0] measured_angle;
        logic signed [31:0] gyro_rate;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] fused_angle;
        logic signed [31:0] corrected_rate;
    } out_item_t;

    // Divider start, busy and done signals.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    // Saturating add or subtract.
    function automatic fx_t sat_addsub(input fx_t a, input fx_t b, input logic sub);
        logic signed [DATA_WIDTH:0] s;
        begin
            s = sub ? ({a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b})
                    : ({a[DATA_WIDTH-1], a} + {b[DATA_WIDTH-1], b});
            if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
                return s[DATA_WIDTH] ? MIN_FX : MAX_FX;
            end
            return s[DATA_WIDTH-1:0];
        end
    endfunction

    // Round a signed product to nearest, ties away from zero, then saturate.
    function automatic fx_t round_sat(input logic signed [PROD_WIDTH-1:0] p);
        logic [PROD_WIDTH-1:0] m;
        logic [PROD_WIDTH-1:0] r;
        logic neg;
        begin
            neg = p[PROD_WIDTH-1];
            m = neg ? (~p + 1'b1) : p;
            r = (m + (PROD_WIDTH'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (neg) begin
                if (r > PROD_WIDTH'(MAX_FX) + 1) return MIN_FX;
                return fx_t'(~r + 1'b1);
            end
            if (r > PROD_WIDTH'(MAX_FX)) return MAX_FX;
            return fx_t'(r);
        end
    endfunction
endpackage

[rtl/core/kagf_div.sv]
// Restoring divider: (a << FRAC_BITS) / b, truncated toward zero, saturated; zero if b is zero.
`timescale 1ns / 1ps
module kagf_div
    import kagf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  fx_t      num,
    input  fx_t      den,
    output div_ctl_t ctl,
    output fx_t      quot
);
    localparam int NW = DATA_WIDTH + FRAC_BITS;

    logic [NW-1:0]         num_reg, num_next;
    logic [NW-1:0]         q_reg, q_next;
    logic [DATA_WIDTH:0]   rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] d_reg, d_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] n_mag;

    // One quotient bit per cycle while busy.
    always_comb begin
        n_mag     = num[DATA_WIDTH-1] ? (~num + 1'b1) : num;
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[DATA_WIDTH-1:0], num_reg[NW-1]};
        if (start) begin
            num_next  = {n_mag, {FRAC_BITS{1'b0}}};
            d_next    = den[DATA_WIDTH-1] ? (~den + 1'b1) : den;
            neg_next  = num[DATA_WIDTH-1] ^ den[DATA_WIDTH-1];
            zero_next = (den == '0);
            q_next    = '0;
            rem_next  = '0;
            cnt_next  = CNT_WIDTH'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            if (trial >= {1'b0, d_reg}) begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg  <= num_next;
        q_reg    <= q_next;
        rem_reg  <= rem_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    // Apply sign and saturate; a zero divisor gives zero.
    always_comb begin
        if (zero_reg) begin
            quot = '0;
        end else if (neg_reg) begin
            if (q_reg > NW'(MAX_FX) + 1) quot = MIN_FX;
            else quot = fx_t'(~q_reg + 1'b1);
        end else begin
            if (q_reg > NW'(MAX_FX)) quot = MAX_FX;
            else quot = fx_t'(q_reg);
        end
        ctl.start = start;
        ctl.busy  = busy_reg;
        ctl.done  = done_reg;
    end
endmodule

[rtl/core/kalman_angle_gyro_fusion.sv]
// Top level of the two-state angle and gyro-bias Kalman filter.
//
// Input channel s_*: one beat carries a measured angle and a gyro rate,
// signed Q16.16. Output channel m_*: one beat per input beat with the fused
// angle and the bias-corrected rate, in input order.
// Configuration: cfg_we writes cfg_data to register cfg_index at once
// (0 sample period, 1 angle noise, 2 bias noise, 3 measurement noise).
// Each item passes through the prediction products, two divisions each
// with its start step, the correction products and one output step. One
// item is in flight at a time; s_ready is low from acceptance until the
// result register is free again. The pace is set by the bit-serial divider
// and the single shared 32x32 multiplier.
// Reset clears the state to angle 0, bias 0, covariance identity, and
// loads the default register values. If the receiver stalls, the result
// holds in the output register and no new item is taken.
`timescale 1ns / 1ps
module kalman_angle_gyro_fusion
    import kagf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_we,
    input  logic [IDX_WIDTH-1:0]  cfg_index,
    input  logic [CFG_WIDTH-1:0]  cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_PRED_A, S_PRED_P00, S_PRED_P01, S_PRED_P11,
        S_DIV0, S_DIV0_W, S_DIV1, S_DIV1_W,
        S_C00, S_C01, S_C10, S_C11, S_CA, S_CB, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [CFG_WIDTH-1:0] dt_reg, qa_reg, qb_reg, rm_reg;
    fx_t ang_reg, ang_next, bias_reg, bias_next;
    fx_t p00_reg, p00_next, p01_reg, p01_next, p10_reg, p10_next, p11_reg, p11_next;
    fx_t meas_reg, meas_next, gyro_reg, gyro_next;
    fx_t k0_reg, k0_next, k1_reg, k1_next, err_reg, err_next;
    fx_t q00_reg, q00_next, q01_reg, q01_next;
    logic mphase_reg, mphase_next;
    fx_t ma_reg, ma_next, mb_reg, mb_next;
    logic signed [PROD_WIDTH-1:0] prod_reg;
    fx_t prod_fx;
    logic div_start;
    fx_t div_num, div_den, div_q;
    div_ctl_t div_ctl;
    logic m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    fx_t e_val, rate_val;

    kagf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .ctl     (div_ctl),
        .quot    (div_q)
    );

    // Shared multiplier, registered.
    always_ff @(posedge aclk) begin
        prod_reg <= ma_reg * mb_reg;
    end
    assign prod_fx = round_sat(prod_reg);

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign e_val   = sat_addsub(fx_t'({1'b0, rm_reg}), p00_reg, 1'b0);

    // Sequencer: each multiply step loads operands, then uses the product.
    always_comb begin
        state_next   = state_reg;
        ang_next     = ang_reg;
        bias_next    = bias_reg;
        p00_next     = p00_reg;
        p01_next     = p01_reg;
        p10_next     = p10_reg;
        p11_next     = p11_reg;
        meas_next    = meas_reg;
        gyro_next    = gyro_reg;
        k0_next      = k0_reg;
        k1_next      = k1_reg;
        err_next     = err_reg;
        q00_next     = q00_reg;
        q01_next     = q01_reg;
        mphase_next  = 1'b0;
        ma_next      = ma_reg;
        mb_next      = mb_reg;
        div_start    = 1'b0;
        div_num      = p00_reg;
        div_den      = e_val;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rate_val     = '0;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    meas_next  = s_data.measured_angle;
                    gyro_next  = s_data.gyro_rate;
                    ma_next    = sat_addsub(s_data.gyro_rate, bias_reg, 1'b1);
                    mb_next    = fx_t'({1'b0, dt_reg});
                    state_next = S_PRED_A;
                end
            end
            S_PRED_A: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    ang_next = sat_addsub(ang_reg, prod_fx, 1'b0);
                    ma_next = sat_addsub(sat_addsub(fx_t'({1'b0, qa_reg}), p01_reg, 1'b1),
                                         p10_reg, 1'b1);
                    state_next = S_PRED_P00;
                end
            end
            S_PRED_P00: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    p00_next   = sat_addsub(p00_reg, prod_fx, 1'b0);
                    ma_next    = sat_addsub('0, p11_reg, 1'b1);
                    state_next = S_PRED_P01;
                end
            end
            S_PRED_P01: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    p01_next   = sat_addsub(p01_reg, prod_fx, 1'b0);
                    p10_next   = sat_addsub(p10_reg, prod_fx, 1'b0);
                    ma_next    = fx_t'({1'b0, qb_reg});
                    state_next = S_PRED_P11;
                end
            end
            S_PRED_P11: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    p11_next   = sat_addsub(p11_reg, prod_fx, 1'b0);
                    err_next   = sat_addsub(meas_reg, ang_reg, 1'b1);
                    state_next = S_DIV0;
                end
            end
            S_DIV0: begin
                div_start  = 1'b1;
                div_num    = p00_reg;
                state_next = S_DIV0_W;
            end
            S_DIV0_W: begin
                if (div_ctl.done) begin
                    k0_next    = div_q;
                    state_next = S_DIV1;
                end
            end
            S_DIV1: begin
                div_start  = 1'b1;
                div_num    = p10_reg;
                state_next = S_DIV1_W;
            end
            S_DIV1_W: begin
                if (div_ctl.done) begin
                    k1_next    = div_q;
                    q00_next   = p00_reg;
                    q01_next   = p01_reg;
                    ma_next    = k0_reg;
                    mb_next    = p00_reg;
                    state_next = S_C00;
                end
            end
            S_C00: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    p00_next   = sat_addsub(q00_reg, prod_fx, 1'b1);
                    mb_next    = q01_reg;
                    state_next = S_C01;
                end
            end
            S_C01: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    p01_next   = sat_addsub(q01_reg, prod_fx, 1'b1);
                    ma_next    = k1_reg;
                    mb_next    = q00_reg;
                    state_next = S_C10;
                end
            end
            S_C10: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    p10_next   = sat_addsub(p10_reg, prod_fx, 1'b1);
                    mb_next    = q01_reg;
                    state_next = S_C11;
                end
            end
            S_C11: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    p11_next   = sat_addsub(p11_reg, prod_fx, 1'b1);
                    ma_next    = k0_reg;
                    mb_next    = err_reg;
                    state_next = S_CA;
                end
            end
            S_CA: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    ang_next   = sat_addsub(ang_reg, prod_fx, 1'b0);
                    ma_next    = k1_reg;
                    state_next = S_CB;
                end
            end
            S_CB: begin
                mphase_next = !mphase_reg;
                if (mphase_reg) begin
                    bias_next  = sat_addsub(bias_reg, prod_fx, 1'b0);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                rate_val = sat_addsub(gyro_reg, bias_reg, 1'b1);
                m_data_next.fused_angle    = ang_reg;
                m_data_next.corrected_rate = rate_val;
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state, configuration and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mphase_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            dt_reg      <= RST_SAMPLE_PERIOD;
            qa_reg      <= RST_ANGLE_NOISE;
            qb_reg      <= RST_BIAS_NOISE;
            rm_reg      <= RST_MEAS_NOISE;
            ang_reg     <= '0;
            bias_reg    <= '0;
            p00_reg     <= ONE_FX;
            p01_reg     <= '0;
            p10_reg     <= '0;
            p11_reg     <= ONE_FX;
        end else begin
            state_reg   <= state_next;
            mphase_reg  <= mphase_next;
            m_valid_reg <= m_valid_next;
            ang_reg     <= ang_next;
            bias_reg    <= bias_next;
            p00_reg     <= p00_next;
            p01_reg     <= p01_next;
            p10_reg     <= p10_next;
            p11_reg     <= p11_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_SAMPLE_PERIOD: dt_reg <= cfg_data;
                    REG_ANGLE_NOISE:   qa_reg <= cfg_data;
                    REG_BIAS_NOISE:    qb_reg <= cfg_data;
                    REG_MEAS_NOISE:    rm_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        meas_reg   <= meas_next;
        gyro_reg   <= gyro_next;
        k0_reg     <= k0_next;
        k1_reg     <= k1_next;
        err_reg    <= err_next;
        q00_reg    <= q00_next;
        q01_reg    <= q01_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        m_data_reg <= m_data_next;
    end
endmodule

[rtl/core/kagf_checker.sv]
// Port-level checker for the Kalman filter top level, with its bind.
`timescale 1ns / 1ps
`include "kalman_angle_gyro_fusion_macros.svh"
module kagf_port_props
    import kagf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);
    `KAG_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat taken while busy")
    `KAG_ASSERT_IMPL(a_no_take_with_result, aclk, aresetn, m_valid, !s_ready, "input taken while result pending")
    `KAG_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped under stall")
    `KAG_ASSERT_NEXT(a_result_after_take, aclk, aresetn, s_valid && s_ready, !m_valid, "result too early")
endmodule

bind kalman_angle_gyro_fusion kagf_port_props u_kagf_port_props (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
